[rtl/core/kbm_pkg.sv]
`timescale 1ns / 1ps

package kbm_pkg;

	localparam int SAMPLE_W = 6;
	localparam int LEVEL_W  = 6;
	localparam int CTR_W    = 8;
	localparam int MARGIN_W = 7;
	localparam int REPORT_W = 5;
	localparam int BTN_N    = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 16;

	localparam logic [CTR_W-1:0]    CTR_TOP       = 8'hFF;
	localparam logic [CTR_W-1:0]    CTR_MID       = 8'h80;
	localparam logic [LEVEL_W-1:0]  LEVEL_RESET   = 6'd63;
	localparam logic [LEVEL_W-1:0]  LEVEL_FLOOR   = 6'd1;
	localparam logic [LEVEL_W-1:0]  MAX_VOL_RESET = 6'd63;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET  = 7'd40;

	localparam logic [CFG_IDX_W-1:0] CFG_VOL_LIMIT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_MARGIN = 2'd1;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	typedef struct packed {
		logic               down;
		logic               up;
		logic [LEVEL_W-1:0] level_nx;
		logic [LEVEL_W-1:0] level_cur;
	} knob_res_t;

	typedef struct packed {
		logic             changed;
		logic [BTN_N-1:0] pressed;
	} btn_res_t;

endpackage

[rtl/core/kbm_knob.sv]
`timescale 1ns / 1ps

module kbm_knob (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [kbm_pkg::SAMPLE_W-1:0]  sample,
	input  logic [kbm_pkg::LEVEL_W-1:0]   vol_limit,
	input  logic [kbm_pkg::MARGIN_W-1:0]  slope_margin,
	output kbm_pkg::knob_res_t            res
);

	logic [kbm_pkg::LEVEL_W-1:0] level_q, level_nx;
	logic [kbm_pkg::CTR_W-1:0]   ctr_q, ctr_nx;
	logic                        first_q, first_nx;
	logic                        down, up;
	logic [kbm_pkg::CTR_W-1:0]   margin_ext;

	assign margin_ext = {1'b0, slope_margin};

	always_comb begin
		level_nx = level_q;
		ctr_nx   = ctr_q;
		first_nx = first_q;
		down     = 1'b0;
		up       = 1'b0;
		if (first_q) begin
			// sync level to the knob, no report
			level_nx = sample;
			first_nx = 1'b0;
		end else if (level_q > sample) begin
			if (ctr_q != '0) begin
				ctr_nx = ctr_q - 8'd1;
			end else begin
				ctr_nx = margin_ext;
				if (level_q > kbm_pkg::LEVEL_FLOOR) begin
					level_nx = level_q - 6'd1;
					down     = 1'b1;
				end
			end
		end else if (level_q < sample) begin
			if (ctr_q != kbm_pkg::CTR_TOP) begin
				ctr_nx = ctr_q + 8'd1;
			end else begin
				ctr_nx = kbm_pkg::CTR_TOP - margin_ext;
				if (level_q < vol_limit) begin
					level_nx = level_q + 6'd1;
					up       = 1'b1;
				end
			end
		end else begin
			// drift back toward the middle
			if (ctr_q > kbm_pkg::CTR_MID) begin
				ctr_nx = ctr_q - 8'd1;
			end else if (ctr_q < kbm_pkg::CTR_MID) begin
				ctr_nx = ctr_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= kbm_pkg::LEVEL_RESET;
			ctr_q   <= kbm_pkg::CTR_MID;
			first_q <= 1'b1;
		end else if (advance) begin
			level_q <= level_nx;
			ctr_q   <= ctr_nx;
			first_q <= first_nx;
		end
	end

	assign res.down      = down;
	assign res.up        = up;
	assign res.level_nx  = level_nx;
	assign res.level_cur = level_q;

endmodule

[rtl/core/kbm_btn.sv]
`timescale 1ns / 1ps

module kbm_btn (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [kbm_pkg::BTN_N-1:0]  now,
	output kbm_pkg::btn_res_t          res
);

	logic [kbm_pkg::BTN_N-1:0] held_q;
	logic [kbm_pkg::BTN_N-1:0] diff;

	assign diff        = now ^ held_q;
	assign res.changed = |diff;
	// only press edges set report bits; releases just count as a change
	assign res.pressed = diff & now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (advance) begin
			held_q <= now;
		end
	end

endmodule

[rtl/core/knob_and_button_media_report_unit.sv]
`timescale 1ns / 1ps
// Channel | Dir | Handshake              | Payload
// s_axis  | in  | s_axis_tvalid/tready   | tdata: sample[5:0] next[6] prev[7] pause[8]; tuser: kind
// m_axis  | out | m_axis_tvalid/tready   | tdata: report[4:0] level[10:5]; tlast: release
// cfg     | in  | cfg_valid/cfg_ready    | cfg_index: 0 vol_limit, 1 slope_margin; cfg_data
//
// An item is registered on entry and evaluated against the result register once that register is free.
// An item that changes nothing sends no output; one that reports fills the single result register,
// which sends the report and then the release item.
// Reset clears the level to 63, the slope counter to 128 and the held buttons.
// A stalled m_axis holds the result register; the input register then fills and stalls s_axis.

module knob_and_button_media_report_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [kbm_pkg::S_DATA_W-1:0]      s_axis_tdata,  // sample[5:0] next[6] prev[7] pause[8]
	input  logic                              s_axis_tuser,  // req_type
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [kbm_pkg::M_DATA_W-1:0]      m_axis_tdata,  // report[4:0] level[10:5]
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [kbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [kbm_pkg::LEVEL_W-1:0]  vol_limit_q;
	logic [kbm_pkg::MARGIN_W-1:0] slope_margin_q;

	logic                         in_valid_s1;
	logic                         in_type_s1;
	logic [kbm_pkg::SAMPLE_W-1:0] in_sample_s1;
	logic [kbm_pkg::BTN_N-1:0]    in_btn_s1;

	logic                         out_valid_q;
	logic                         out_last_q;
	logic [kbm_pkg::REPORT_W-1:0] out_report_q;
	logic [kbm_pkg::LEVEL_W-1:0]  out_level_q;

	logic                         proc;
	logic                         changed;
	logic [kbm_pkg::REPORT_W-1:0] report;
	logic [kbm_pkg::LEVEL_W-1:0]  level;
	kbm_pkg::knob_res_t           knob_res;
	kbm_pkg::btn_res_t            btn_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_limit_q    <= kbm_pkg::MAX_VOL_RESET;
			slope_margin_q <= kbm_pkg::MARGIN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				kbm_pkg::CFG_VOL_LIMIT:    vol_limit_q    <= cfg_data[kbm_pkg::LEVEL_W-1:0];
				kbm_pkg::CFG_SLOPE_MARGIN: slope_margin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// evaluate when the result register is free or its release item leaves now
	assign proc = in_valid_s1 && (!out_valid_q || (m_axis_tready && out_last_q));
	assign s_axis_tready = !in_valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_type_s1   <= s_axis_tuser;
			in_sample_s1 <= s_axis_tdata[kbm_pkg::SAMPLE_W-1:0];
			in_btn_s1    <= s_axis_tdata[kbm_pkg::SAMPLE_W+kbm_pkg::BTN_N-1:kbm_pkg::SAMPLE_W];
		end
	end

	kbm_knob u_knob (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (proc && (in_type_s1 == kbm_pkg::REQ_SAMPLE)),
		.sample       (in_sample_s1),
		.vol_limit    (vol_limit_q),
		.slope_margin (slope_margin_q),
		.res          (knob_res)
	);

	kbm_btn u_btn (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (proc && (in_type_s1 == kbm_pkg::REQ_TICK)),
		.now     (in_btn_s1),
		.res     (btn_res)
	);

	always_comb begin
		if (in_type_s1 == kbm_pkg::REQ_TICK) begin
			report  = {btn_res.pressed, 2'b00};
			changed = btn_res.changed;
			level   = knob_res.level_cur;
		end else begin
			report  = {3'b000, knob_res.up, knob_res.down};
			changed = knob_res.up || knob_res.down;
			level   = knob_res.level_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (proc && changed) begin
			out_valid_q <= 1'b1;
			out_last_q  <= 1'b0;
		end else if (out_valid_q && m_axis_tready) begin
			// report taken: follow with the release item, else drain
			out_valid_q <= !out_last_q;
			out_last_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && changed) begin
			out_report_q <= report;
			out_level_q  <= level;
		end else if (out_valid_q && m_axis_tready) begin
			out_report_q <= '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{(kbm_pkg::M_DATA_W-kbm_pkg::REPORT_W-kbm_pkg::LEVEL_W){1'b0}},
				out_level_q, out_report_q};

endmodule

[rtl/core/kbm_chk.sv]
`timescale 1ns / 1ps

module kbm_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [kbm_pkg::M_DATA_W-1:0]   m_axis_tdata,
	input logic                           m_axis_tlast
);

	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[4:0] == 5'd0))
		else $error("release item carries report bits");

	a_release_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
		else $error("report item not followed by release item");

	a_release_level: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tdata[10:5] == $past(m_axis_tdata[10:5])))
		else $error("release item level differs from report level");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:11] == 5'd0))
		else $error("tdata padding not zero");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("tvalid dropped while stalled");

endmodule

bind knob_and_button_media_report_unit kbm_chk u_kbm_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
